>>> hw/rtl/skvt_pkg.sv
package skvt_pkg;

    // Default table depth
    localparam int CAPACITY_DEF = 256;

    // Request modes
    typedef enum logic [3:0] {
        MODE_LOOKUP     = 4'd0,
        MODE_INSERT     = 4'd1,
        MODE_UPSERT     = 4'd2,
        MODE_REMOVE_KEY = 4'd3,
        MODE_REMOVE_POS = 4'd4,
        MODE_WRITE_POS  = 4'd5,
        MODE_READ_POS   = 4'd6,
        MODE_INS_POS    = 4'd7,
        MODE_CLEAR      = 4'd8
    } t_mode;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_DONE    = 3'd0,
        STAT_ABSENT  = 3'd1,
        STAT_PRESENT = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_RANGE   = 3'd4
    } t_status;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SRCH_END,
        S_POS_CHK,
        S_POS_RD,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_RESULT
    } t_state;

    // Read address source
    typedef enum logic [2:0] {
        RD_NONE,
        RD_MID,
        RD_LO,
        RD_POS,
        RD_IDX_DN,
        RD_IDX_UP
    } t_rd_sel;

    // Write operation
    typedef enum logic [2:0] {
        WR_NONE,
        WR_NEW_AT_LO,
        WR_VAL_AT_LO,
        WR_VAL_AT_POS,
        WR_MOVE_IDX
    } t_wr_sel;

    // Shift index update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_FROM_COUNT,
        IDX_FROM_LO,
        IDX_FROM_POS,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    // Entry count update
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } t_cnt_op;

    // Result position source
    typedef enum logic [1:0] {
        RPOS_ZERO,
        RPOS_LO,
        RPOS_REQ
    } t_rpos_sel;

    // Result value source
    typedef enum logic {
        RVAL_ZERO,
        RVAL_RD
    } t_rval_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic      load;
        t_rd_sel   rd_sel;
        logic      step;
        t_wr_sel   wr_sel;
        t_idx_op   idx_op;
        t_cnt_op   cnt_op;
        logic      res_load;
        t_status   res_status;
        t_rpos_sel res_pos_sel;
        t_rval_sel res_val_sel;
        logic      emit;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic lt_hi;
        logic rd_key_lt;
        logic found;
        logic full;
        logic pos_ok;
        logic idx_gt_lo;
        logic idx_more;
    } t_dp_stat;

endpackage

>>> hw/rtl/skvt_dp.sv
module skvt_dp #(
    parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_key,
    input  logic [31:0]        i_value,
    input  logic [7:0]         i_position,
    input  skvt_pkg::t_dp_cmd  i_cmd,
    output skvt_pkg::t_dp_stat o_stat,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic [8:0]         o_position_res,
    output logic [31:0]        o_value_res,
    output logic [8:0]         o_entry_count
);
    import skvt_pkg::*;

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CW1 = CW + 1;
    localparam int XW  = (CW > 8) ? CW : 8;

    // Key and value memories
    logic [31:0] key_mem [CAPACITY];
    logic [31:0] val_mem [CAPACITY];

    // Request, search and shift registers
    logic [31:0]   r_key;
    logic [31:0]   r_val;
    logic [7:0]    r_pos;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [31:0]   r_rd_key;
    logic [31:0]   r_rd_val;

    // Result registers
    t_status     r_res_status;
    logic [8:0]  r_res_pos;
    logic [31:0] r_res_val;
    logic        r_o_done;
    logic [2:0]  r_o_status;
    logic [8:0]  r_o_pos;
    logic [31:0] r_o_val;
    logic [8:0]  r_o_cnt;

    logic [CW:0]   w_sum;
    logic [CW-1:0] w_mid;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_key_en;
    logic          wr_val_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_key_d;
    logic [31:0]   wr_val_d;

    // Midpoint of the search window
    assign w_sum = CW1'(r_lo) + CW1'(r_hi);
    assign w_mid = w_sum[CW:1];

    // Read address select
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = AW'(r_lo);
        case (i_cmd.rd_sel)
            RD_MID:    rd_addr = AW'(w_mid);
            RD_LO:     rd_addr = AW'(r_lo);
            RD_POS:    rd_addr = AW'(r_pos);
            RD_IDX_DN: rd_addr = AW'(r_idx - 1'b1);
            RD_IDX_UP: rd_addr = AW'(r_idx + 1'b1);
            default:   rd_en   = 1'b0;
        endcase
    end

    // Write port select
    always_comb begin
        wr_key_en = 1'b0;
        wr_val_en = 1'b0;
        wr_addr   = AW'(r_lo);
        wr_key_d  = r_key;
        wr_val_d  = r_val;
        case (i_cmd.wr_sel)
            WR_NEW_AT_LO: begin
                wr_key_en = 1'b1;
                wr_val_en = 1'b1;
            end
            WR_VAL_AT_LO: begin
                wr_val_en = 1'b1;
            end
            WR_VAL_AT_POS: begin
                wr_val_en = 1'b1;
                wr_addr   = AW'(r_pos);
            end
            WR_MOVE_IDX: begin
                wr_key_en = 1'b1;
                wr_val_en = 1'b1;
                wr_addr   = AW'(r_idx);
                wr_key_d  = r_rd_key;
                wr_val_d  = r_rd_val;
            end
            default: ;
        endcase
    end

    // Key memory
    always_ff @(posedge i_clk) begin
        if (wr_key_en) begin
            key_mem[wr_addr] <= wr_key_d;
        end
        if (rd_en) begin
            r_rd_key <= key_mem[rd_addr];
        end
    end

    // Value memory
    always_ff @(posedge i_clk) begin
        if (wr_val_en) begin
            val_mem[wr_addr] <= wr_val_d;
        end
        if (rd_en) begin
            r_rd_val <= val_mem[rd_addr];
        end
    end

    // Status back to the controller
    always_comb begin
        o_stat.lt_hi     = r_lo < r_hi;
        o_stat.rd_key_lt = r_rd_key < r_key;
        o_stat.found     = (r_lo < r_count) && (r_rd_key == r_key);
        o_stat.full      = r_count >= CW'(CAPACITY);
        o_stat.pos_ok    = XW'(r_pos) < XW'(r_count);
        o_stat.idx_gt_lo = r_idx > r_lo;
        o_stat.idx_more  = (CW1'(r_idx) + 1'b1) < CW1'(r_count);
    end

    // Next entry count
    always_comb begin
        n_count = r_count;
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + 1'b1;
            CNT_DEC: n_count = r_count - 1'b1;
            CNT_CLR: n_count = '0;
            default: ;
        endcase
    end

    // Count and search window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load) begin
                r_lo <= '0;
                r_hi <= r_count;
            end else if (i_cmd.step) begin
                if (o_stat.rd_key_lt) begin
                    r_lo <= w_mid + 1'b1;
                end else begin
                    r_hi <= w_mid;
                end
            end
        end
    end

    // Request latch and shift index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
            r_val <= i_value;
            r_pos <= i_position;
        end
        case (i_cmd.idx_op)
            IDX_FROM_COUNT: r_idx <= r_count;
            IDX_FROM_LO:    r_idx <= r_lo;
            IDX_FROM_POS:   r_idx <= CW'(r_pos);
            IDX_DEC:        r_idx <= r_idx - 1'b1;
            IDX_INC:        r_idx <= r_idx + 1'b1;
            default: ;
        endcase
    end

    // Result fields held until the transaction ends
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_pos_sel)
                RPOS_LO:  r_res_pos <= 9'(r_lo);
                RPOS_REQ: r_res_pos <= 9'(r_pos);
                default:  r_res_pos <= '0;
            endcase
            r_res_val <= (i_cmd.res_val_sel == RVAL_RD) ? r_rd_val : '0;
        end
    end

    // Output register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_done <= 1'b0;
        end else begin
            r_o_done <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_o_status <= r_res_status;
            r_o_pos    <= r_res_pos;
            r_o_val    <= r_res_val;
            r_o_cnt    <= 9'(r_count);
        end
    end

    assign o_done         = r_o_done;
    assign o_status       = r_o_status;
    assign o_position_res = r_o_pos;
    assign o_value_res    = r_o_val;
    assign o_entry_count  = r_o_cnt;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("search window inverted");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_done |=> !r_o_done)
        else $error("result strobe longer than one cycle");

    a_inc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cnt_op == CNT_INC) |=> (r_count != '0))
        else $error("entry count wrapped on insert");
`endif

endmodule

>>> hw/rtl/skvt_ctrl.sv
module skvt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [3:0]         i_mode,
    input  skvt_pkg::t_dp_stat i_stat,
    output skvt_pkg::t_dp_cmd  o_cmd,
    output logic               busy
);
    import skvt_pkg::*;

    t_state r_state;
    t_state n_state;
    t_mode  r_mode;
    t_mode  w_req_mode;

    assign w_req_mode = t_mode'(i_mode);
    assign busy       = (r_state != S_IDLE);

    // State and mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == S_IDLE && start) begin
            r_mode <= w_req_mode;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (w_req_mode) inside
                        MODE_LOOKUP, MODE_INSERT, MODE_UPSERT, MODE_REMOVE_KEY,
                        MODE_INS_POS:
                            n_state = S_SRCH_RD;
                        MODE_REMOVE_POS, MODE_WRITE_POS, MODE_READ_POS:
                            n_state = S_POS_CHK;
                        default:
                            n_state = S_RESULT;
                    endcase
                end
            end
            S_SRCH_RD:  n_state = i_stat.lt_hi ? S_SRCH_CMP : S_SRCH_END;
            S_SRCH_CMP: n_state = S_SRCH_RD;
            S_SRCH_END: begin
                n_state = S_RESULT;
                unique case (r_mode) inside
                    MODE_INSERT, MODE_UPSERT: begin
                        if (!i_stat.found && !i_stat.full) begin
                            n_state = S_UP_RD;
                        end
                    end
                    MODE_REMOVE_KEY: begin
                        if (i_stat.found) begin
                            n_state = S_DN_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_POS_CHK: begin
                n_state = S_RESULT;
                if (i_stat.pos_ok && r_mode != MODE_WRITE_POS) begin
                    n_state = S_POS_RD;
                end
            end
            S_POS_RD: n_state = (r_mode == MODE_REMOVE_POS) ? S_DN_RD : S_RESULT;
            S_UP_RD:  n_state = i_stat.idx_gt_lo ? S_UP_WR : S_RESULT;
            S_UP_WR:  n_state = S_UP_RD;
            S_DN_RD:  n_state = i_stat.idx_more ? S_DN_WR : S_RESULT;
            S_DN_WR:  n_state = S_DN_RD;
            S_RESULT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    unique case (w_req_mode) inside
                        MODE_LOOKUP, MODE_INSERT, MODE_UPSERT, MODE_REMOVE_KEY,
                        MODE_INS_POS, MODE_REMOVE_POS, MODE_WRITE_POS,
                        MODE_READ_POS: ;
                        MODE_CLEAR: begin
                            o_cmd.cnt_op   = CNT_CLR;
                            o_cmd.res_load = 1'b1;
                        end
                        default: begin
                            o_cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SRCH_RD: begin
                o_cmd.rd_sel = i_stat.lt_hi ? RD_MID : RD_LO;
            end
            S_SRCH_CMP: begin
                o_cmd.step = 1'b1;
            end
            S_SRCH_END: begin
                o_cmd.res_load    = 1'b1;
                o_cmd.res_pos_sel = RPOS_LO;
                unique case (r_mode) inside
                    MODE_LOOKUP: begin
                        if (i_stat.found) begin
                            o_cmd.res_val_sel = RVAL_RD;
                        end else begin
                            o_cmd.res_status = STAT_ABSENT;
                        end
                    end
                    MODE_INSERT, MODE_UPSERT: begin
                        if (i_stat.found) begin
                            if (r_mode == MODE_UPSERT) begin
                                o_cmd.wr_sel = WR_VAL_AT_LO;
                            end else begin
                                o_cmd.res_status = STAT_PRESENT;
                            end
                        end else if (i_stat.full) begin
                            o_cmd.res_status = STAT_FULL;
                        end else begin
                            o_cmd.idx_op = IDX_FROM_COUNT;
                        end
                    end
                    MODE_REMOVE_KEY: begin
                        if (i_stat.found) begin
                            o_cmd.res_val_sel = RVAL_RD;
                            o_cmd.idx_op      = IDX_FROM_LO;
                        end else begin
                            o_cmd.res_status = STAT_ABSENT;
                        end
                    end
                    default: ;
                endcase
            end
            S_POS_CHK: begin
                if (!i_stat.pos_ok) begin
                    o_cmd.res_load    = 1'b1;
                    o_cmd.res_status  = STAT_RANGE;
                    o_cmd.res_pos_sel = RPOS_REQ;
                end else if (r_mode == MODE_WRITE_POS) begin
                    o_cmd.wr_sel      = WR_VAL_AT_POS;
                    o_cmd.res_load    = 1'b1;
                    o_cmd.res_pos_sel = RPOS_REQ;
                end else begin
                    o_cmd.rd_sel = RD_POS;
                end
            end
            S_POS_RD: begin
                o_cmd.res_load    = 1'b1;
                o_cmd.res_pos_sel = RPOS_REQ;
                o_cmd.res_val_sel = RVAL_RD;
                if (r_mode == MODE_REMOVE_POS) begin
                    o_cmd.idx_op = IDX_FROM_POS;
                end
            end
            S_UP_RD: begin
                if (i_stat.idx_gt_lo) begin
                    o_cmd.rd_sel = RD_IDX_DN;
                end else begin
                    o_cmd.wr_sel = WR_NEW_AT_LO;
                    o_cmd.cnt_op = CNT_INC;
                end
            end
            S_UP_WR: begin
                o_cmd.wr_sel = WR_MOVE_IDX;
                o_cmd.idx_op = IDX_DEC;
            end
            S_DN_RD: begin
                if (i_stat.idx_more) begin
                    o_cmd.rd_sel = RD_IDX_UP;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                end
            end
            S_DN_WR: begin
                o_cmd.wr_sel = WR_MOVE_IDX;
                o_cmd.idx_op = IDX_INC;
            end
            S_RESULT: begin
                o_cmd.emit = 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("result emitted outside the closing state");

    a_shift_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_WR || r_state == S_DN_WR) |-> $past(o_cmd.rd_sel != RD_NONE))
        else $error("entry moved without a preceding read");
`endif

endmodule

>>> hw/rtl/sorted_key_value_table.sv
// A key request runs a binary search of at most clog2(CAPACITY)+1 halving steps, each a memory
// read then a compare; a position request checks the range and, unless it writes, reads the
// entry; clear and unused modes go straight to the result. Every successful insert or removal
// then moves the later entries one at a time, each with one memory read, then one write.
// Throughput: one transaction at a time; busy is low again in the cycle of the result strobe.
// Reset clears the entry count and the controller, not the memories; the receiver cannot stall.
module sorted_key_value_table #(
    parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_mode,
    input  logic [31:0] i_key,
    input  logic [31:0] i_value,
    input  logic [7:0]  i_position,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [8:0]  o_position_res,
    output logic [31:0] o_value_res,
    output logic [8:0]  o_entry_count
);
    import skvt_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer
    skvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    // Table storage and search datapath
    skvt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key          (i_key),
        .i_value        (i_value),
        .i_position     (i_position),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_position_res (o_position_res),
        .o_value_res    (o_value_res),
        .o_entry_count  (o_entry_count)
    );

endmodule

>>> tb/sv/tb.sv
module tb;
    import skvt_pkg::*;

    // Codes above the last defined mode are no-ops
    localparam logic [3:0] MODE_UNUSED_LO = 4'(MODE_CLEAR) + 4'd1;
    localparam logic [3:0] MODE_UNUSED_HI = 4'hF;
    localparam int         STALL_LIMIT    = 4000;

    // One result transaction as the table should report it
    typedef struct packed {
        t_status     status;
        logic [8:0]  position;
        logic [31:0] value;
        logic [8:0]  count;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_mode;
    logic [31:0] i_key;
    logic [31:0] i_value;
    logic [7:0]  i_position;
    logic        o_done;
    logic [2:0]  o_status;
    logic [8:0]  o_position_res;
    logic [31:0] o_value_res;
    logic [8:0]  o_entry_count;

    // Shadow copy of the table contents
    logic [31:0] table_key [0:CAPACITY_DEF-1];
    logic [31:0] table_val [0:CAPACITY_DEF-1];
    int          table_count;

    t_reply      pending_replies [$];
    int          mismatch_count;
    int          stall_cycles;
    bit          idle_on;
    bit          wide_keys;

    sorted_key_value_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_key          (i_key),
        .i_value        (i_value),
        .i_position     (i_position),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_position_res (o_position_res),
        .o_value_res    (o_value_res),
        .o_entry_count  (o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    // Drop one entry, moving the later ones down; returns its value
    function automatic logic [31:0] close_gap(int idx);
        logic [31:0] gone;
        int          i;
        gone = table_val[idx];
        for (i = idx; i + 1 < table_count; i++) begin
            table_key[i] = table_key[i + 1];
            table_val[i] = table_val[i + 1];
        end
        table_count--;
        return gone;
    endfunction

    // Apply one request to the shadow table and work out its result
    function automatic t_reply apply_to_table(logic [3:0] mode, logic [31:0] key,
                                              logic [31:0] value, logic [7:0] pos);
        t_reply rep;
        int     where;
        int     i;
        bit     found;
        bit     pos_ok;
        rep   = '{STAT_DONE, 9'd0, 32'd0, 9'd0};
        where = 0;
        for (i = 0; i < table_count; i++)
            if (table_key[i] < key)
                where++;
        found  = (where < table_count) && (table_key[where] == key);
        pos_ok = pos < table_count;

        case (mode)
            MODE_LOOKUP: begin
                rep.position = 9'(where);
                if (found)
                    rep.value = table_val[where];
                else
                    rep.status = STAT_ABSENT;
            end
            MODE_INSERT, MODE_UPSERT: begin
                rep.position = 9'(where);
                if (found) begin
                    if (mode == MODE_UPSERT)
                        table_val[where] = value;
                    else
                        rep.status = STAT_PRESENT;
                end else if (table_count >= CAPACITY_DEF) begin
                    rep.status = STAT_FULL;
                end else begin
                    for (i = table_count; i > where; i--) begin
                        table_key[i] = table_key[i - 1];
                        table_val[i] = table_val[i - 1];
                    end
                    table_count++;
                    table_key[where] = key;
                    table_val[where] = value;
                end
            end
            MODE_REMOVE_KEY: begin
                rep.position = 9'(where);
                if (found)
                    rep.value = close_gap(where);
                else
                    rep.status = STAT_ABSENT;
            end
            MODE_REMOVE_POS: begin
                rep.position = 9'(pos);
                if (pos_ok)
                    rep.value = close_gap(int'(pos));
                else
                    rep.status = STAT_RANGE;
            end
            MODE_WRITE_POS: begin
                rep.position = 9'(pos);
                if (pos_ok)
                    table_val[pos] = value;
                else
                    rep.status = STAT_RANGE;
            end
            MODE_READ_POS: begin
                rep.position = 9'(pos);
                if (pos_ok)
                    rep.value = table_val[pos];
                else
                    rep.status = STAT_RANGE;
            end
            MODE_INS_POS: rep.position = 9'(where);
            MODE_CLEAR:   table_count = 0;
            default: ;
        endcase
        rep.count = 9'(table_count);
        return rep;
    endfunction

    // Present one request and hold it until the table takes it
    task automatic send_request(logic [3:0] mode, logic [31:0] key,
                                logic [31:0] value, logic [7:0] pos);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      <= 1'b1;
        i_mode     <= mode;
        i_key      <= key;
        i_value    <= value;
        i_position <= pos;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_replies.push_back(apply_to_table(mode, key, value, pos));
    endtask

    // Stored key, or one from a pool: narrow pool gives plenty of collisions
    function automatic logic [31:0] pick_key(bit stored);
        int r;
        if (stored && table_count > 0)
            return table_key[$urandom_range(0, table_count - 1)];
        r = $urandom_range(0, 9);
        if (wide_keys || r == 0)
            return $urandom();
        if (r == 1)
            return 32'h0000_0000;
        if (r == 2)
            return 32'hFFFF_FFFF;
        return 32'($urandom_range(0, 63)) * 32'h0400_0001;
    endfunction

    // Mostly near the valid range, sometimes anywhere
    function automatic logic [7:0] pick_position();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, (table_count > 255) ? 255 : table_count));
    endfunction

    // Every request but insert and upsert on an empty table
    task automatic test_empty_table();
        send_request(MODE_LOOKUP, 32'h0000_0000, 32'h0, 8'd0);
        send_request(MODE_REMOVE_KEY, 32'hFFFF_FFFF, 32'h0, 8'd0);
        send_request(MODE_REMOVE_POS, 32'h0, 32'h0, 8'd0);
        send_request(MODE_WRITE_POS, 32'h0, 32'hFFFF_FFFF, 8'd255);
        send_request(MODE_READ_POS, 32'h0, 32'h0, 8'd0);
        send_request(MODE_INS_POS, 32'h1234_5678, 32'h0, 8'd0);
        send_request(MODE_CLEAR, 32'h0, 32'h0, 8'd0);
        send_request(MODE_UNUSED_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
    endtask

    // Small table: duplicates, updates, hits and misses, range checks
    task automatic test_basic_ops();
        send_request(MODE_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 8'd0);
        send_request(MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 8'd0);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        send_request(MODE_INSERT, 32'h8000_0000, 32'h1111_1111, 8'd0);
        send_request(MODE_UPSERT, 32'h8000_0000, 32'h5A5A_5A5A, 8'd0);
        send_request(MODE_UPSERT, 32'h7FFF_FFFF, 32'h0000_0001, 8'd0);
        send_request(MODE_LOOKUP, 32'h8000_0000, 32'h0, 8'd0);
        send_request(MODE_LOOKUP, 32'h8000_0001, 32'h0, 8'd0);
        send_request(MODE_READ_POS, 32'h0, 32'h0, 8'd3);
        send_request(MODE_WRITE_POS, 32'h0, 32'h0F0F_F0F0, 8'd0);
        send_request(MODE_READ_POS, 32'h0, 32'h0, 8'd4);
        send_request(MODE_INS_POS, 32'hFFFF_FFFF, 32'h0, 8'd0);
        send_request(MODE_REMOVE_POS, 32'h0, 32'h0, 8'd1);
        send_request(MODE_REMOVE_KEY, 32'hFFFF_FFFF, 32'h0, 8'd0);
        send_request(MODE_REMOVE_KEY, 32'hFFFF_FFFF, 32'h0, 8'd0);
        send_request(MODE_UNUSED_LO, 32'h0, 32'h0, 8'd0);
        send_request(MODE_CLEAR, 32'h0, 32'h0, 8'd0);
        send_request(MODE_LOOKUP, 32'h0, 32'h0, 8'd0);
    endtask

    // Fill to capacity, then full, boundary and whole-table shift cases
    task automatic test_full_table(bit shuffled);
        logic [31:0] key;
        send_request(MODE_CLEAR, 32'h0, 32'h0, 8'd0);
        while (table_count < CAPACITY_DEF) begin
            if (shuffled) begin
                key = $urandom();
                send_request(MODE_UPSERT, key, $urandom(), 8'd0);
            end else begin
                key = (32'(table_count) << 24) | 32'h0000_0080;
                send_request(MODE_INSERT, key, $urandom(), 8'd0);
            end
        end
        send_request(MODE_INSERT, 32'h0000_0000, $urandom(), 8'd0);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, $urandom(), 8'd0);
        send_request(MODE_INSERT, table_key[100] + 32'd1, $urandom(), 8'd0);
        send_request(MODE_UPSERT, table_key[255], $urandom(), 8'd0);
        send_request(MODE_INSERT, table_key[17], $urandom(), 8'd0);
        send_request(MODE_UPSERT, 32'hFFFF_FFFF, $urandom(), 8'd0);
        send_request(MODE_READ_POS, 32'h0, 32'h0, 8'd255);
        send_request(MODE_WRITE_POS, 32'h0, $urandom(), 8'd255);
        send_request(MODE_LOOKUP, table_key[255], 32'h0, 8'd0);
        send_request(MODE_INS_POS, 32'hFFFF_FFFF, 32'h0, 8'd0);
        send_request(MODE_REMOVE_POS, 32'h0, 32'h0, 8'd0);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, $urandom(), 8'd0);
        send_request(MODE_REMOVE_POS, 32'h0, 32'h0, 8'd255);
        send_request(MODE_INSERT, 32'h0000_0000, $urandom(), 8'd0);
        send_request(MODE_REMOVE_KEY, table_key[128], 32'h0, 8'd0);
        send_request(MODE_CLEAR, 32'h0, 32'h0, 8'd0);
    endtask

    // Random mix; each phase of 100 picks a target size, key pool and idling
    task automatic test_random_mix(int n_items);
        int          target;
        int          r;
        int          n;
        logic [3:0]  mode;
        logic [31:0] key;
        target = 8;
        for (n = 0; n < n_items; n++) begin
            if (n % 100 == 0) begin
                target    = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 80)
                                                        : $urandom_range(1, 20);
                wide_keys = $urandom_range(0, 2) == 0;
                idle_on   = $urandom_range(0, 3) != 0;
            end
            r   = $urandom_range(0, 99);
            key = pick_key(1'($urandom_range(0, 1)));
            if (r < 28) begin
                // steer the size toward the target
                if (table_count < target) begin
                    mode = r[0] ? MODE_INSERT : MODE_UPSERT;
                    key  = pick_key(1'b0);
                end else begin
                    mode = r[0] ? MODE_REMOVE_KEY : MODE_REMOVE_POS;
                    key  = pick_key(1'b1);
                end
            end else if (r < 38) begin
                mode = r[0] ? MODE_INSERT : MODE_UPSERT;
                key  = pick_key(1'b1);
            end else if (r < 50) begin
                mode = MODE_LOOKUP;
            end else if (r < 56) begin
                mode = MODE_REMOVE_KEY;
            end else if (r < 62) begin
                mode = MODE_REMOVE_POS;
            end else if (r < 71) begin
                mode = MODE_WRITE_POS;
            end else if (r < 82) begin
                mode = MODE_READ_POS;
            end else if (r < 93) begin
                mode = MODE_INS_POS;
            end else if (r < 98) begin
                mode = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            end else begin
                mode = MODE_CLEAR;
            end
            send_request(mode, key, $urandom(), pick_position());
        end
    endtask

    // Compare each result transaction with the oldest outstanding one
    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: result with nothing outstanding: status %0d position %0d",
                         $time, o_status, o_position_res);
                $display("%0t: value %h count %0d", $time, o_value_res, o_entry_count);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    mismatch_count++;
                end
                if (o_position_res !== want.position) begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, o_position_res);
                    mismatch_count++;
                end
                if (o_value_res !== want.value) begin
                    $display("%0t: value expected %h actual %h",
                             $time, want.value, o_value_res);
                    mismatch_count++;
                end
                if (o_entry_count !== want.count) begin
                    $display("%0t: entry count expected %0d actual %0d",
                             $time, want.count, o_entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: cycles with neither a request nor a result transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_mode         = MODE_LOOKUP;
        i_key          = 32'h0;
        i_value        = 32'h0;
        i_position     = 8'h0;
        table_count    = 0;
        mismatch_count = 0;
        stall_cycles   = 0;
        idle_on        = 1'b1;
        wide_keys      = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_basic_ops();
        test_full_table(1'b0);
        test_random_mix(800);
        idle_on = 1'b1;
        test_full_table(1'b1);

        // drain, then let any trailing activity settle
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
